/* rtl/swtl_pkg.sv */
// Shared constants, types and helpers for the sorted word table lookup unit.
// No dependencies; the unit and the testbench refer to this package by scoped names.
package swtl_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 16384;
    localparam int WORD_CHARS  = 5;
    localparam int WORD_W      = 8 * WORD_CHARS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // Range bounds must hold the depth itself.
    localparam int CNT_W       = ADDR_W + 1;

    // Ranges shorter than this are scanned linearly; bisection needs two entries.
    localparam int SCAN_LIMIT  = 10;
    localparam int BIS_MIN     = (SCAN_LIMIT > 2) ? SCAN_LIMIT : 2;

    // Configuration registers.
    localparam int CFG_W       = 15;
    localparam int SUM_W       = CFG_W + 1;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam logic REG_ANSWER_COUNT     = 1'b0;
    localparam logic REG_DICTIONARY_COUNT = 1'b1;

    // Item actions.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Search sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIS_RD,
        ST_BIS_CMP,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Cut a region bound to the table depth.
    function automatic logic [CNT_W-1:0] clip_bound(input logic [SUM_W-1:0] bound);
        logic [SUM_W:0] wide;
        wide = {1'b0, bound};
        if (wide > (SUM_W+1)'(TABLE_DEPTH)) begin
            return CNT_W'(TABLE_DEPTH);
        end
        return CNT_W'(bound);
    endfunction

endpackage

/* rtl/swtl_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module swtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sorted_word_table_lookup_unit.sv */
// Sorted word table lookup unit: table memory, configuration registers and search sequencer.
// Depends on swtl_pkg and swtl_ram.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries items with an action, an
// entry index and a 40-bit packed word. A load item writes the word into the table at
// the entry index in the cycle it is accepted and gives no result. A query item searches
// the answer region, indices 0 .. answer_count-1, and then the dictionary region that
// follows it, and gives one result item with o_found on the output channel
// (o_out_valid / i_out_ready). Both regions must be sorted ascending and loaded first.
// Each region search bisects while the range holds ten or more entries, one step being a
// table read and then a compare, and then scans the rest at one entry per cycle.
// The table memory has a single read port; a query result passes through ST_DONE into the
// output register.
// The unit works on one item at a time; o_in_ready is high only while it is idle.
// A finished result waits in the output register; a stalled receiver holds the next
// query in its final state, but the next item can be accepted while a result waits.
// The APB port writes answer_count at address 0 and dictionary_count at address 4; the user
// must write them only while the unit is idle, as the unit does not enforce it. Reset clears
// both counts and the control state; the table contents are undefined until written.
module sorted_word_table_lookup_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [swtl_pkg::ADDR_W-1:0]   i_entry_index,
    input  logic [swtl_pkg::WORD_W-1:0]   i_word,
    // Result item channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swtl_pkg::PADDR_W-1:0]  paddr,
    input  logic [swtl_pkg::PDATA_W-1:0]  pwdata,
    output logic [swtl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int CNT_W  = swtl_pkg::CNT_W;
    localparam int ADDR_W = swtl_pkg::ADDR_W;
    localparam int WORD_W = swtl_pkg::WORD_W;
    localparam int CFG_W  = swtl_pkg::CFG_W;
    localparam int SUM_W  = swtl_pkg::SUM_W;

    // Configuration registers.
    logic [CFG_W-1:0] r_answer_count;
    logic [CFG_W-1:0] r_dict_count;
    logic             cfg_write;

    // Sequencer registers and next values.
    swtl_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_start, n_start;
    logic [CNT_W-1:0] r_end, n_end;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_scan_idx, n_scan_idx;
    logic             r_scan_pend, n_scan_pend;
    logic             r_region, n_region;
    logic             r_hit, n_hit;
    logic [WORD_W-1:0] r_word, n_word;
    logic             r_out_valid, n_out_valid;
    logic             r_found, n_found;

    // Memory port signals.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    // Helper values.
    logic             in_fire;
    logic [CNT_W-1:0] range_len;
    logic [CNT_W-1:0] mid_calc;
    logic             scan_issue;
    logic [CNT_W-1:0] dict_start;
    logic [CNT_W-1:0] dict_end;
    logic [CNT_W-1:0] ans_end;

    // Table memory.
    swtl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (swtl_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_entry_index),
        .i_wdata (i_word),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Configuration write and read.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_answer_count <= '0;
            r_dict_count   <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                swtl_pkg::REG_ANSWER_COUNT:     r_answer_count <= pwdata[CFG_W-1:0];
                swtl_pkg::REG_DICTIONARY_COUNT: r_dict_count   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            swtl_pkg::REG_ANSWER_COUNT:     prdata = swtl_pkg::PDATA_W'(r_answer_count);
            swtl_pkg::REG_DICTIONARY_COUNT: prdata = swtl_pkg::PDATA_W'(r_dict_count);
            default:                        prdata = '0;
        endcase
    end

    // Region bounds, cut to the table depth.
    assign ans_end    = swtl_pkg::clip_bound(SUM_W'(r_answer_count));
    assign dict_start = ans_end;
    assign dict_end   = swtl_pkg::clip_bound(SUM_W'(r_answer_count) + SUM_W'(r_dict_count));

    // Input handshake; loads go straight into the table.
    assign o_in_ready = (r_state == swtl_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign mem_we     = in_fire && (i_action == swtl_pkg::ACT_LOAD);

    // Bisection midpoint and scan issue test.
    assign range_len  = r_end - r_start;
    assign mid_calc   = r_start + (range_len >> 1);
    assign scan_issue = (r_scan_idx < r_end);

    // Read address: midpoint while bisecting, scan pointer otherwise.
    always_comb begin
        if (r_state == swtl_pkg::ST_BIS_RD) begin
            mem_raddr = mid_calc[ADDR_W-1:0];
        end else begin
            mem_raddr = r_scan_idx[ADDR_W-1:0];
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swtl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_scan_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_scan_pend <= n_scan_pend;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_end      <= n_end;
        r_mid      <= n_mid;
        r_scan_idx <= n_scan_idx;
        r_region   <= n_region;
        r_hit      <= n_hit;
        r_word     <= n_word;
        r_found    <= n_found;
    end

    // Next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_end       = r_end;
        n_mid       = r_mid;
        n_scan_idx  = r_scan_idx;
        n_scan_pend = r_scan_pend;
        n_region    = r_region;
        n_hit       = r_hit;
        n_word      = r_word;
        n_found     = r_found;
        n_out_valid = r_out_valid;

        // The receiver takes a waiting result.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            swtl_pkg::ST_IDLE: begin
                if (in_fire && (i_action == swtl_pkg::ACT_QUERY)) begin
                    n_word   = i_word;
                    n_start  = '0;
                    n_end    = ans_end;
                    n_region = 1'b0;
                    n_state  = swtl_pkg::ST_BIS_RD;
                end
            end

            // Read the midpoint, or fall into the linear scan on a short range.
            swtl_pkg::ST_BIS_RD: begin
                if (range_len >= CNT_W'(swtl_pkg::BIS_MIN)) begin
                    n_mid   = mid_calc;
                    n_state = swtl_pkg::ST_BIS_CMP;
                end else begin
                    n_scan_idx  = r_start;
                    n_scan_pend = 1'b0;
                    n_state     = swtl_pkg::ST_SCAN;
                end
            end

            // Compare against the midpoint entry and halve the range.
            swtl_pkg::ST_BIS_CMP: begin
                if (r_word == mem_rdata) begin
                    n_hit   = 1'b1;
                    n_state = swtl_pkg::ST_DONE;
                end else begin
                    if (r_word < mem_rdata) begin
                        n_end = r_mid;
                    end else begin
                        n_start = r_mid;
                    end
                    n_state = swtl_pkg::ST_BIS_RD;
                end
            end

            // Pipelined scan: issue one address per cycle, compare the entry read last cycle.
            swtl_pkg::ST_SCAN: begin
                if (r_scan_pend && (r_word == mem_rdata)) begin
                    n_hit       = 1'b1;
                    n_scan_pend = 1'b0;
                    n_state     = swtl_pkg::ST_DONE;
                end else if (!scan_issue && !r_scan_pend) begin
                    if (!r_region) begin
                        // Answer region missed; search the dictionary region next.
                        n_region = 1'b1;
                        n_start  = dict_start;
                        n_end    = dict_end;
                        n_state  = swtl_pkg::ST_BIS_RD;
                    end else begin
                        n_hit   = 1'b0;
                        n_state = swtl_pkg::ST_DONE;
                    end
                end else begin
                    n_scan_pend = scan_issue;
                    if (scan_issue) begin
                        n_scan_idx = r_scan_idx + CNT_W'(1);
                    end
                end
            end

            // Hand the result to the output register once it is free.
            swtl_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_hit       = 1'b0;
                    n_state     = swtl_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = swtl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

endmodule

/* tb/tb_sorted_word_table_lookup_unit.sv */
// Self-checking testbench for the sorted word table lookup unit.
// It loads each table entry a query reads on first use, sets the region counts over APB
// and checks each query result. Depends on swtl_pkg and the unit's RTL.
module tb_sorted_word_table_lookup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int QUIET_CYCLES = 100;
    localparam int TOTAL_ITEMS  = 1100;
    localparam int TABLE_DEPTH  = swtl_pkg::TABLE_DEPTH;
    localparam int ADDR_W       = swtl_pkg::ADDR_W;
    localparam int WORD_W       = swtl_pkg::WORD_W;
    localparam int CFG_W        = swtl_pkg::CFG_W;
    localparam int PADDR_W      = swtl_pkg::PADDR_W;
    localparam int PDATA_W      = swtl_pkg::PDATA_W;
    localparam int SCAN_LIMIT   = swtl_pkg::SCAN_LIMIT;
    localparam int LAST_ENTRY   = TABLE_DEPTH - 1;
    localparam int COUNT_MAX    = (1 << CFG_W) - 1;
    localparam logic [WORD_W-1:0] WORD_MAX = '1;

    // Mirror of the word table and region counts; predicts the found flag of every query.
    class found_scoreboard;
        bit   [WORD_W-1:0] table_words [TABLE_DEPTH];
        bit                written [TABLE_DEPTH];
        bit   [CFG_W-1:0]  answer_count;
        bit   [CFG_W-1:0]  dictionary_count;
        bit                pending_found [$];
        int unsigned       to_fill [$];
        int unsigned       mismatches;
        int unsigned       results;
        int unsigned       hits;
        int unsigned       loads;

        // Ascending word an entry receives when a query first needs it.
        function bit [WORD_W-1:0] base_word(int unsigned i);
            if (i == LAST_ENTRY) return WORD_MAX;
            return {ADDR_W'(i), (WORD_W - ADDR_W)'(i * 40503)};
        endfunction

        // Word held at an entry, or the word it will be given on first use.
        function bit [WORD_W-1:0] entry_word(int unsigned i);
            return written[i] ? table_words[i] : base_word(i);
        endfunction

        // Reads one entry on the search path and notes it when it still has to be loaded.
        function bit [WORD_W-1:0] read_entry(int unsigned i, bit note);
            if (note && !written[i]) to_fill.push_back(i);
            return entry_word(i);
        endfunction

        // Bisect while the range is long enough, then scan what is left.
        function bit region_has_word(int unsigned lo, int unsigned hi, bit [WORD_W-1:0] w,
                                     bit note);
            int unsigned mid;
            bit [WORD_W-1:0] t;
            if (lo > TABLE_DEPTH) lo = TABLE_DEPTH;
            if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
            if (hi < lo) hi = lo;
            while (hi - lo >= SCAN_LIMIT && hi - lo >= 2) begin
                mid = lo + (hi - lo) / 2;
                t = read_entry(mid, note);
                if (t == w) return 1'b1;
                if (w < t) hi = mid;
                else lo = mid;
            end
            for (int unsigned i = lo; i < hi; i++) begin
                if (read_entry(i, note) == w) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Searches the answer region, then the dictionary region.
        function bit query_found(bit [WORD_W-1:0] w, bit note);
            bit found;
            found = region_has_word(0, int'(answer_count), w, note);
            if (!found) begin
                found = region_has_word(int'(answer_count),
                                        int'(answer_count) + int'(dictionary_count), w, note);
            end
            return found;
        endfunction

        // Lists the entries a query of this word reads that were never loaded.
        function void plan_query(bit [WORD_W-1:0] w);
            to_fill.delete();
            void'(query_found(w, 1'b1));
        endfunction

        function void write_register(int unsigned index, logic [PDATA_W-1:0] value);
            if (index == swtl_pkg::REG_ANSWER_COUNT) answer_count = value[CFG_W-1:0];
            else if (index == swtl_pkg::REG_DICTIONARY_COUNT)
                dictionary_count = value[CFG_W-1:0];
        endfunction

        // A load updates the mirror; a query queues its expected found flag.
        function void note_item(logic action, logic [ADDR_W-1:0] index, logic [WORD_W-1:0] w);
            if (action == swtl_pkg::ACT_LOAD) begin
                table_words[index] = w;
                written[index] = 1'b1;
                loads++;
                return;
            end
            pending_found.push_back(query_found(w, 1'b0));
        endfunction

        function void check_found(logic found);
            bit expected;
            if (pending_found.size() == 0) begin
                $display("%0t ns: result with no query waiting: expected none, actual found=%0b",
                         $time, found);
                mismatches++;
                return;
            end
            expected = pending_found.pop_front();
            results++;
            if (expected) hits++;
            if (found !== expected) begin
                $display("%0t ns: found mismatch: expected %0b, actual %0b",
                         $time, expected, found);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_action;
    logic [ADDR_W-1:0]   i_entry_index;
    logic [WORD_W-1:0]   i_word;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_found;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    found_scoreboard sb;
    int gap_max;
    int stall_max;
    int idle_cycles;
    int items_sent;
    int settings_used;

    sorted_word_table_lookup_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_word        (i_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Sends one item after a random gap and holds it until the unit takes it.
    task automatic send_item(input logic action, input logic [ADDR_W-1:0] index,
                             input logic [WORD_W-1:0] w);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_action      <= action;
        i_entry_index <= index;
        i_word        <= w;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Loads every entry the query will read that was never written, then sends the query.
    task automatic send_query(input logic [WORD_W-1:0] w);
        int unsigned idx;
        sb.plan_query(w);
        while (sb.to_fill.size() != 0) begin
            idx = sb.to_fill.pop_front();
            send_item(swtl_pkg::ACT_LOAD, ADDR_W'(idx), sb.base_word(idx));
        end
        send_item(swtl_pkg::ACT_QUERY, ADDR_W'($urandom), w);
    endtask

    // Waits until every query has answered and the unit has had time to finish any load.
    task automatic settle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.pending_found.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // APB write of one region count; the bits above the count field carry random noise.
    task automatic write_count(input logic reg_index, input int unsigned value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= {17'($urandom), CFG_W'(value)};
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regions(input int unsigned answers, input int unsigned words);
        write_count(swtl_pkg::REG_ANSWER_COUNT, answers);
        write_count(swtl_pkg::REG_DICTIONARY_COUNT, words);
        settings_used++;
    endtask

    // Result receiver: stalls a random number of cycles before taking each result.
    initial begin : result_receiver
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                @(negedge i_clk) i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Monitors on the three channels, plus the count of cycles with no transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_item(i_action, i_entry_index, i_word);
            if (o_out_valid && i_out_ready) sb.check_found(o_found);
            if (psel && penable && pwrite && pready) sb.write_register(int'(paddr >> 2), pwdata);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("[sorted_word_table_lookup_unit] ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] saved;
        int n;
        int a;
        int d;
        int span;
        int count;
        int pick;
        int mode;
        int unsigned idx;

        sb            = new;
        idle_cycles   = 0;
        items_sent    = 0;
        settings_used = 0;
        gap_max       = 18;
        stall_max     = 18;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = swtl_pkg::ACT_LOAD;
        i_entry_index = '0;
        i_word        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Both regions empty after reset: no entry is read and nothing is found.
        send_item(swtl_pkg::ACT_QUERY, '1, '0);
        send_item(swtl_pkg::ACT_QUERY, '0, WORD_MAX);

        // Both counts at the table depth: the dictionary starts past the memory and is empty.
        settle();
        set_regions(TABLE_DEPTH, TABLE_DEPTH);
        send_query(sb.entry_word(0));
        send_query(sb.entry_word(LAST_ENTRY));
        send_query(sb.entry_word(TABLE_DEPTH / 2 - 1) + 1'b1);
        send_query(sb.entry_word(700));

        // Empty answer region, full dictionary.
        settle();
        set_regions(0, TABLE_DEPTH);
        send_query(sb.entry_word(LAST_ENTRY));
        send_query(sb.entry_word(0));
        send_query(sb.entry_word(3) + 1'b1);

        // Largest counts the registers hold: both regions are cut at the table end.
        settle();
        set_regions(COUNT_MAX, COUNT_MAX);
        send_query(sb.entry_word(1234));

        // Dictionary of five entries cut down to the last table entry.
        settle();
        set_regions(LAST_ENTRY, 5);
        send_query(sb.entry_word(LAST_ENTRY));
        send_query(sb.entry_word(LAST_ENTRY - 1));

        // Nine answers are scanned; ten dictionary words take one bisection step.
        settle();
        set_regions(9, 10);
        send_query(sb.entry_word(8));
        send_query(sb.entry_word(9));
        send_query(sb.entry_word(18));
        send_query(sb.entry_word(14));
        send_query(sb.entry_word(19));

        // One entry in each region, then a load into the dictionary entry.
        settle();
        set_regions(1, 1);
        send_query(sb.entry_word(0));
        send_query(sb.entry_word(1));
        send_query(sb.entry_word(2));
        settle();
        saved = sb.entry_word(1);
        send_item(swtl_pkg::ACT_LOAD, ADDR_W'(1), WORD_MAX);
        send_query(WORD_MAX);
        send_item(swtl_pkg::ACT_LOAD, ADDR_W'(1), saved);

        // Random phases, each with its own region counts and idling pattern.
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 4;
                default: gap_max = 18;
            endcase
            case ($urandom_range(0, 3))
                0:       stall_max = 0;
                1:       stall_max = 4;
                default: stall_max = 18;
            endcase
            mode = $urandom_range(0, 2);
            n = TABLE_DEPTH;
            if (mode == 0) begin
                // Small table at the bottom: close words with repeats.
                n = $urandom_range(1, 40);
                w = WORD_W'({$urandom, $urandom});
                if (w > WORD_MAX - 200) w = WORD_MAX - 200;
                for (int i = 0; i < n; i++) begin
                    send_item(swtl_pkg::ACT_LOAD, ADDR_W'(i), w);
                    w = w + WORD_W'($urandom_range(0, 3));
                end
                settle();
                a = $urandom_range(0, n);
                d = $urandom_range(0, n - a);
            end else if (mode == 1) begin
                a = $urandom_range(0, TABLE_DEPTH);
                d = $urandom_range(0, TABLE_DEPTH);
            end else begin
                // Regions near or past the end of the memory.
                a = $urandom_range(0, 1) ? $urandom_range(TABLE_DEPTH - 60, TABLE_DEPTH)
                                         : $urandom_range(0, COUNT_MAX);
                d = $urandom_range(0, COUNT_MAX);
            end
            set_regions(a, d);
            span = (a + d > TABLE_DEPTH) ? TABLE_DEPTH : a + d;
            count = $urandom_range(20, 60);
            for (int q = 0; q < count && items_sent < TOTAL_ITEMS; q++) begin
                pick = $urandom_range(0, 99);
                idx = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, LAST_ENTRY);
                w = sb.entry_word(idx);
                if (pick < 10) begin
                    // Loads in the middle of a phase: a slight change in the small table,
                    // the stored word written back anywhere else.
                    if (mode == 0) begin
                        idx = $urandom_range(0, n - 1);
                        send_item(swtl_pkg::ACT_LOAD, ADDR_W'(idx),
                                  sb.table_words[idx] + WORD_W'($urandom_range(0, 1)));
                    end else begin
                        idx = $urandom_range(0, LAST_ENTRY);
                        send_item(swtl_pkg::ACT_LOAD, ADDR_W'(idx), sb.entry_word(idx));
                    end
                end else if (pick < 25) begin
                    send_query(WORD_W'({$urandom, $urandom}));
                end else if (pick < 45) begin
                    send_query($urandom_range(0, 1) ? w + 1'b1 : w - 1'b1);
                end else begin
                    send_query(w);
                end
            end
        end

        settle();
        $display("Checked %0d query results (%0d hits) over %0d loads and %0d region settings.",
                 sb.results, sb.hits, sb.loads, settings_used);
        $display("Mismatches: %0d, queries left unanswered: %0d",
                 sb.mismatches, sb.pending_found.size());
        if (sb.mismatches == 0 && sb.pending_found.size() == 0) begin
            $display("[sorted_word_table_lookup_unit] OK");
        end else begin
            $display("[sorted_word_table_lookup_unit] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/swtl_pkg.sv
rtl/swtl_ram.sv
rtl/sorted_word_table_lookup_unit.sv
tb/tb_sorted_word_table_lookup_unit.sv
